// File: sv/cdsd_pkg.sv
package cdsd_pkg;

  localparam int CMD_W  = 3;
  localparam int CARD_W = 8;
  localparam int RND_W  = 32;
  localparam int IDX_W  = 6;
  localparam int STAT_W = 3;
  localparam int LEFT_W = 7;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STEP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEAL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DONE  = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

// File: sv/cdsd_mod_serial.sv
module cdsd_mod_serial #(
  parameter int DIV_W = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cdsd_pkg::RND_W-1:0]   dividend,
  input  logic [DIV_W-1:0]             divisor,
  output logic [DIV_W-1:0]             rem,
  output cdsd_pkg::mod_stat_t          stat
);

  localparam int RW = cdsd_pkg::RND_W;
  localparam int CW = $clog2(RW + 1);

  logic [RW-1:0]    word_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] rem_nxt;
  logic [DIV_W-1:0] div_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   div_ext;

  // one quotient bit per cycle, msb first
  always_comb begin
    trial   = {rem_r, word_r[RW-1]};
    div_ext = {1'b0, div_r};
    if (trial >= div_ext) begin
      rem_nxt = DIV_W'(trial - div_ext);
    end else begin
      rem_nxt = DIV_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
        word_r <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        word_r <= {word_r[RW-2:0], 1'b0};
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("remainder unit restarted while busy");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < div_r) else $error("remainder not below divisor");

endmodule

// File: sv/card_deck_shuffle_deal.sv
// Card deck store with one-step-per-command Fisher-Yates shuffle. A command is taken when
// start is high and busy is low; each command gives exactly one result, shown for one
// cycle with out_valid high, and the receiver cannot stall it. Clear, load, start
// shuffle, unused codes, a step with nothing left to swap and commands that end in an
// error report in the cycle after the transaction, so one such command can be taken every
// cycle. Deal and read pass ST_RD and then report from ST_RD_OUT, a delay set by the
// registered read port of the card memory. A shuffle step that swaps first loads the
// remainder unit, then forms the bit-serial remainder of the random word by the cursor,
// one quotient bit per cycle, then passes the remainder to the memory address, and
// ends with the two reads and two writes of the swap on the single write port, the
// last write also registering the result. The card memory is not cleared; a card is only
// read after it was loaded.
module card_deck_shuffle_deal #(
  parameter int DECK_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cdsd_pkg::CMD_W-1:0]    in_cmd,
  input  logic [cdsd_pkg::CARD_W-1:0]   in_card_in,
  input  logic [cdsd_pkg::RND_W-1:0]    in_random_word,
  input  logic [cdsd_pkg::IDX_W-1:0]    in_read_index,
  output logic                          out_valid,
  output logic [cdsd_pkg::CARD_W-1:0]   out_card_out,
  output logic [cdsd_pkg::STAT_W-1:0]   out_status,
  output logic [cdsd_pkg::LEFT_W-1:0]   out_cards_left
);

  localparam int AW    = $clog2(DECK_DEPTH);
  localparam int CNT_W = $clog2(DECK_DEPTH + 1);
  localparam int LW    = cdsd_pkg::LEFT_W;
  localparam int DW    = cdsd_pkg::CARD_W;
  localparam int IW    = cdsd_pkg::IDX_W;
  localparam int CMPW  = (CNT_W > IW) ? CNT_W : IW;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DECK_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SW_LO,
    ST_SW_HI,
    ST_SW_WR_LO,
    ST_SW_WR_HI,
    ST_RD,
    ST_RD_OUT
  } state_t;

  state_t                     state_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           cursor_r;
  logic [AW-1:0]              addr_r;
  logic [AW-1:0]              lo_r;
  logic [AW-1:0]              hi_r;
  logic [DW-1:0]              tmp_r;
  logic [DW-1:0]              rdata_r;
  logic                       out_valid_r;
  logic [DW-1:0]              out_card_r;
  logic [cdsd_pkg::STAT_W-1:0] out_status_r;
  logic [LW-1:0]              out_left_r;

  logic [DW-1:0]              mem [DECK_DEPTH];
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [DW-1:0]              mem_wdata;

  logic                       accept;
  logic                       full;
  logic [CNT_W-1:0]           cnt_dec;
  logic [CMPW-1:0]            idx_ext;
  logic [CMPW-1:0]            cnt_ext;
  logic                       mod_start;
  logic [CNT_W-1:0]           mod_rem;
  cdsd_pkg::mod_stat_t        mod_stat;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign full    = (count_r == DEPTH_C);
  assign cnt_dec = count_r - CNT_W'(1);
  assign idx_ext = CMPW'(in_read_index);
  assign cnt_ext = CMPW'(count_r);
  assign mod_start = accept && (in_cmd == cdsd_pkg::CMD_STEP) && (cursor_r > CNT_W'(1));

  cdsd_mod_serial #(
    .DIV_W (CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_random_word),
    .divisor  (cursor_r),
    .rem      (mod_rem),
    .stat     (mod_stat)
  );

  // single write port, registered read port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = lo_r;
    mem_wdata = rdata_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd == cdsd_pkg::CMD_LOAD) && !full) begin
          mem_we    = 1'b1;
          mem_waddr = count_r[AW-1:0];
          mem_wdata = in_card_in;
        end
      end
      ST_SW_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = rdata_r;
      end
      ST_SW_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = tmp_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            out_card_r   <= '0;
            out_status_r <= cdsd_pkg::STAT_OK;
            out_left_r   <= LW'(count_r);
            case (in_cmd)
              cdsd_pkg::CMD_CLEAR: begin
                count_r     <= '0;
                cursor_r    <= '0;
                out_left_r  <= '0;
                out_valid_r <= 1'b1;
              end
              cdsd_pkg::CMD_LOAD: begin
                if (full) begin
                  out_status_r <= cdsd_pkg::STAT_FULL;
                end else begin
                  count_r    <= count_r + CNT_W'(1);
                  out_left_r <= LW'(count_r + CNT_W'(1));
                end
                out_valid_r <= 1'b1;
              end
              cdsd_pkg::CMD_START: begin
                cursor_r    <= count_r;
                out_valid_r <= 1'b1;
              end
              cdsd_pkg::CMD_STEP: begin
                if (cursor_r <= CNT_W'(1)) begin
                  out_status_r <= cdsd_pkg::STAT_DONE;
                  out_valid_r  <= 1'b1;
                end else begin
                  hi_r    <= AW'(cursor_r - CNT_W'(1));
                  state_r <= ST_MOD;
                end
              end
              cdsd_pkg::CMD_DEAL: begin
                if (count_r == '0) begin
                  out_status_r <= cdsd_pkg::STAT_EMPTY;
                  out_valid_r  <= 1'b1;
                end else begin
                  count_r    <= cnt_dec;
                  out_left_r <= LW'(cnt_dec);
                  addr_r     <= AW'(cnt_dec);
                  if (cursor_r > cnt_dec) begin
                    cursor_r <= cnt_dec;
                  end
                  state_r <= ST_RD;
                end
              end
              cdsd_pkg::CMD_READ: begin
                if (idx_ext >= cnt_ext) begin
                  out_status_r <= cdsd_pkg::STAT_RANGE;
                  out_valid_r  <= 1'b1;
                end else begin
                  addr_r  <= AW'(idx_ext);
                  state_r <= ST_RD;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        ST_MOD: begin
          if (mod_stat.done) begin
            addr_r  <= AW'(mod_rem);
            lo_r    <= AW'(mod_rem);
            state_r <= ST_SW_LO;
          end
        end
        ST_SW_LO: begin
          addr_r  <= hi_r;
          state_r <= ST_SW_HI;
        end
        ST_SW_HI: begin
          tmp_r   <= rdata_r;
          state_r <= ST_SW_WR_LO;
        end
        ST_SW_WR_LO: begin
          state_r <= ST_SW_WR_HI;
        end
        ST_SW_WR_HI: begin
          cursor_r     <= CNT_W'(hi_r);
          out_card_r   <= '0;
          out_status_r <= (hi_r <= AW'(1)) ? cdsd_pkg::STAT_DONE : cdsd_pkg::STAT_OK;
          out_left_r   <= LW'(count_r);
          out_valid_r  <= 1'b1;
          state_r      <= ST_IDLE;
        end
        ST_RD: begin
          state_r <= ST_RD_OUT;
        end
        ST_RD_OUT: begin
          out_card_r  <= rdata_r;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_card_out   = out_card_r;
  assign out_status     = out_status_r;
  assign out_cards_left = out_left_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("card count above deck depth");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r) else $error("shuffle cursor above card count");

  a_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_stat.done |-> state_r == ST_MOD) else $error("remainder done outside step");

  a_idle_mod_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mod_stat.busy) else $error("remainder unit busy while idle");

endmodule
